### src/masked_pixel_to_rgba8_macros.svh
// assertion helpers used by the checker file
`ifndef MASKED_PIXEL_TO_RGBA8_MACROS_SVH
`define MASKED_PIXEL_TO_RGBA8_MACROS_SVH

// same-cycle implication
`define MPR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define MPR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### src/mpr_pkg.sv
package mpr_pkg;

	localparam int CHANNELS  = 3;
	localparam int Q_BITS    = 8;
	// one quotient bit per division stage
	localparam int STEPS     = 8;
	// input register plus the division stages
	localparam int LATENCY   = STEPS + 1;
	localparam int MASK_BITS = 32;
	localparam int IDX_BITS  = 2;

	localparam logic [Q_BITS-1:0] ALPHA_OPAQUE = 8'hFF;

	localparam logic [MASK_BITS-1:0] RED_MASK_RESET   = 32'h00FF_0000;
	localparam logic [MASK_BITS-1:0] GREEN_MASK_RESET = 32'h0000_FF00;
	localparam logic [MASK_BITS-1:0] BLUE_MASK_RESET  = 32'h0000_00FF;

	typedef enum logic [IDX_BITS-1:0] {
		REG_RED_MASK   = 2'd0,
		REG_GREEN_MASK = 2'd1,
		REG_BLUE_MASK  = 2'd2
	} mpr_reg_e;

endpackage

### src/masked_pixel_to_rgba8.sv
// throughput: one pixel per cycle, busy stays low, results cannot be held off
// latency is set by the input register and the eight-stage divide pipeline
// reset: pipeline valid bits clear, channel masks return to 0xFF0000/0xFF00/0xFF
module masked_pixel_to_rgba8 #(
	parameter int PIXEL_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [PIXEL_BITS-1:0]                pixel_word,
	output logic                                 done,
	output logic [mpr_pkg::Q_BITS-1:0]           red_out,
	output logic [mpr_pkg::Q_BITS-1:0]           green_out,
	output logic [mpr_pkg::Q_BITS-1:0]           blue_out,
	output logic [mpr_pkg::Q_BITS-1:0]           alpha_out,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mpr_pkg::IDX_BITS-1:0]         cfg_index,
	input  logic [mpr_pkg::MASK_BITS-1:0]        cfg_data
);

	localparam int W = PIXEL_BITS;
	localparam int N = mpr_pkg::STEPS;

	logic [mpr_pkg::MASK_BITS-1:0] mask [mpr_pkg::CHANNELS];
	logic [W-1:0]                  mask_w [mpr_pkg::CHANNELS];

	logic                          vld_p [N+1];
	logic [W-1:0]                  v_p [N+1][mpr_pkg::CHANNELS];
	logic [W-1:0]                  m_p [N+1][mpr_pkg::CHANNELS];
	logic [W-1:0]                  r_p [N+1][mpr_pkg::CHANNELS];
	logic [mpr_pkg::Q_BITS-1:0]    q_p [N+1][mpr_pkg::CHANNELS];

	logic                          vld_s1;
	logic [W-1:0]                  v_s1 [mpr_pkg::CHANNELS];
	logic [W-1:0]                  m_s1 [mpr_pkg::CHANNELS];

	logic [mpr_pkg::Q_BITS-1:0]    chan [mpr_pkg::CHANNELS];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	mpr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.mask     (mask)
	);

	// fit each mask to the pixel width, zero-extend or truncate
	always_comb begin
		for (int c = 0; c < mpr_pkg::CHANNELS; c++) begin
			logic [W+mpr_pkg::MASK_BITS-1:0] ext;
			ext       = {{W{1'b0}}, mask[c]};
			mask_w[c] = ext[W-1:0];
		end
	end

	// (p & m) / m equals the shifted ratio, the trailing zeros cancel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < mpr_pkg::CHANNELS; c++) begin
			v_s1[c] <= pixel_word & mask_w[c];
			m_s1[c] <= mask_w[c];
		end
	end

	always_comb begin
		vld_p[0] = vld_s1;
		for (int c = 0; c < mpr_pkg::CHANNELS; c++) begin
			v_p[0][c] = v_s1[c];
			m_p[0][c] = m_s1[c];
			r_p[0][c] = '0;
			q_p[0][c] = '0;
		end
	end

	for (genvar s = 0; s < N; s++) begin : g_div
		mpr_div_step #(.W(W)) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_in (vld_p[s]),
			.v_in   (v_p[s]),
			.m_in   (m_p[s]),
			.r_in   (r_p[s]),
			.q_in   (q_p[s]),
			.vld_sn (vld_p[s+1]),
			.v_sn   (v_p[s+1]),
			.m_sn   (m_p[s+1]),
			.r_sn   (r_p[s+1]),
			.q_sn   (q_p[s+1])
		);
	end

	// zero mask reads as zero
	always_comb begin
		for (int c = 0; c < mpr_pkg::CHANNELS; c++) begin
			chan[c] = (m_p[N][c] == '0) ? '0 : q_p[N][c];
		end
	end

	assign done      = vld_p[N];
	assign red_out   = chan[0];
	assign green_out = chan[1];
	assign blue_out  = chan[2];
	assign alpha_out = mpr_pkg::ALPHA_OPAQUE;

endmodule

### src/mpr_cfg_regs.sv
module mpr_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [mpr_pkg::IDX_BITS-1:0]         wr_index,
	input  logic [mpr_pkg::MASK_BITS-1:0]        wr_data,
	output logic [mpr_pkg::MASK_BITS-1:0]        mask [mpr_pkg::CHANNELS]
);

	logic [mpr_pkg::MASK_BITS-1:0] red_q, green_q, blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q   <= mpr_pkg::RED_MASK_RESET;
			green_q <= mpr_pkg::GREEN_MASK_RESET;
			blue_q  <= mpr_pkg::BLUE_MASK_RESET;
		end else if (wr_en) begin
			unique case (mpr_pkg::mpr_reg_e'(wr_index))
				mpr_pkg::REG_RED_MASK:   red_q   <= wr_data;
				mpr_pkg::REG_GREEN_MASK: green_q <= wr_data;
				mpr_pkg::REG_BLUE_MASK:  blue_q  <= wr_data;
				// unknown index is dropped
				default: ;
			endcase
		end
	end

	assign mask[0] = red_q;
	assign mask[1] = green_q;
	assign mask[2] = blue_q;

endmodule

### src/mpr_div_step.sv
module mpr_div_step #(
	parameter int W = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        vld_in,
	input  logic [W-1:0]                v_in [mpr_pkg::CHANNELS],
	input  logic [W-1:0]                m_in [mpr_pkg::CHANNELS],
	input  logic [W-1:0]                r_in [mpr_pkg::CHANNELS],
	input  logic [mpr_pkg::Q_BITS-1:0]  q_in [mpr_pkg::CHANNELS],
	output logic                        vld_sn,
	output logic [W-1:0]                v_sn [mpr_pkg::CHANNELS],
	output logic [W-1:0]                m_sn [mpr_pkg::CHANNELS],
	output logic [W-1:0]                r_sn [mpr_pkg::CHANNELS],
	output logic [mpr_pkg::Q_BITS-1:0]  q_sn [mpr_pkg::CHANNELS]
);

	logic [W-1:0]               r_nx [mpr_pkg::CHANNELS];
	logic [mpr_pkg::Q_BITS-1:0] q_nx [mpr_pkg::CHANNELS];

	// t = 2r + v < 3m, so the digit is 0, 1 or 2
	always_comb begin
		for (int c = 0; c < mpr_pkg::CHANNELS; c++) begin
			logic [W+1:0] t, m1, m2;
			t  = {1'b0, r_in[c], 1'b0} + {2'b00, v_in[c]};
			m1 = {2'b00, m_in[c]};
			m2 = {1'b0, m_in[c], 1'b0};
			if (t >= m2) begin
				r_nx[c] = W'(t - m2);
				q_nx[c] = {q_in[c][mpr_pkg::Q_BITS-2:0], 1'b0} + mpr_pkg::Q_BITS'(2);
			end else if (t >= m1) begin
				r_nx[c] = W'(t - m1);
				q_nx[c] = {q_in[c][mpr_pkg::Q_BITS-2:0], 1'b1};
			end else begin
				r_nx[c] = W'(t);
				q_nx[c] = {q_in[c][mpr_pkg::Q_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= 1'b0;
		end else begin
			vld_sn <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		v_sn <= v_in;
		m_sn <= m_in;
		r_sn <= r_nx;
		q_sn <= q_nx;
	end

endmodule

### src/mpr_checker.sv
`include "masked_pixel_to_rgba8_macros.svh"

module mpr_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               done,
	input logic [mpr_pkg::Q_BITS-1:0]         alpha_out,
	input logic                               cfg_valid,
	input logic                               cfg_ready
);

	localparam int LAT = mpr_pkg::LATENCY;

	// every accepted word comes out after the fixed latency
	`MPR_ASSERT_IMP(a_word_out, clk, arst_n, start && !busy, ##LAT done)

	// no strobe without a word accepted earlier
	`MPR_ASSERT_IMP(a_no_spurious, clk, arst_n, done, $past(start && !busy, LAT))

	// opaque alpha whenever a word is delivered
	`MPR_ASSERT_IMP(a_alpha, clk, arst_n, done, alpha_out == mpr_pkg::ALPHA_OPAQUE)

	// config write never blocks the pixel side
	`MPR_ASSERT_NXT(a_cfg_free, clk, arst_n, cfg_valid && cfg_ready, !busy)

endmodule

bind masked_pixel_to_rgba8 mpr_checker u_mpr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.alpha_out (alpha_out),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
